@@ src/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared constants, types and float32 helpers for the sine/cosine pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package fsc_pkg;

	localparam int unsigned FloatW = 32;
	localparam int unsigned LzW    = 6;

	localparam logic [FloatW-1:0] DefaultNan = 32'h7FC0_0000;
	localparam logic [FloatW-1:0] PosInf     = 32'h7F80_0000;
	localparam logic [FloatW-1:0] QuietBit   = 32'h0040_0000;

	localparam logic [FloatW-1:0] KFourOverPi = 32'h3FA2_F983;
	localparam logic [FloatW-1:0] KRedA       = 32'hBF49_0000;
	localparam logic [FloatW-1:0] KRedB       = 32'hB97D_A000;
	localparam logic [FloatW-1:0] KRedC       = 32'hB322_2169;
	localparam logic [FloatW-1:0] KS0         = 32'hB94C_A1F9;
	localparam logic [FloatW-1:0] KS1         = 32'h3C08_839E;
	localparam logic [FloatW-1:0] KS2         = 32'hBE2A_AAA3;
	localparam logic [FloatW-1:0] KC0         = 32'h37CC_F5CE;
	localparam logic [FloatW-1:0] KC1         = 32'hBAB6_061A;
	localparam logic [FloatW-1:0] KC2         = 32'h3D2A_AAA5;
	localparam logic [FloatW-1:0] KHalf       = 32'h3F00_0000;
	localparam logic [FloatW-1:0] KOne        = 32'h3F80_0000;

	// unrounded value between normalise and round stages
	typedef struct packed {
		logic               spec;
		logic [FloatW-1:0]  spec_bits;
		logic               sign;
		logic signed [11:0] expo;
		logic [25:0]        mant;
	} fsc_unr_t;

	function automatic logic is_nan(input logic [FloatW-1:0] v);
		return v[30:0] > PosInf[30:0];
	endfunction

	function automatic logic [LzW-1:0] lzc48(input logic [47:0] v);
		logic [LzW-1:0] n;
		logic           found;
		n = '0;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found) begin
				if (v[i]) begin
					found = 1'b1;
				end else begin
					n = n + 1'b1;
				end
			end
		end
		return n;
	endfunction

	// mant: [25] hidden, [24:2] fraction, [1] guard, [0] sticky
	function automatic logic [FloatW-1:0] round_pack(input logic s,
			input logic signed [11:0] e, input logic [25:0] m);
		logic [25:0]        mm;
		logic [4:0]         sh;
		logic signed [11:0] shw;
		logic               lost;
		logic               up;
		logic [7:0]         eb;
		logic [24:0]        rnd;
		logic [FloatW-1:0]  tmp;
		if (m == '0) begin
			return {s, 31'b0};
		end
		if (e >= 12'sd255) begin
			return {s, PosInf[30:0]};
		end
		if (e >= 12'sd1) begin
			mm = m;
			eb = e[7:0] - 8'd1;
		end else begin
			shw = 12'sd1 - e;
			sh = (shw > 12'sd30) ? 5'd31 : shw[4:0];
			lost = |(m & ((26'd1 << sh) - 26'd1));
			mm = m >> sh;
			mm[0] = mm[0] | lost;
			eb = 8'd0;
		end
		up = mm[1] & (mm[0] | mm[2]);
		rnd = {1'b0, mm[25:2]} + {24'b0, up};
		tmp = {1'b0, eb, 23'b0} + {7'b0, rnd};
		return {s, tmp[30:0]};
	endfunction

endpackage
`default_nettype wire

@@ src/fsc_if.sv @@
// ----------------------------------------------------------------------------
// fsc_if
// Valid/ready channels for the angle input and the sine/cosine result.
// ----------------------------------------------------------------------------
`default_nettype none
interface fsc_angle_if;
	logic        valid;
	logic        ready;
	logic [31:0] angle_bits;

	modport source (output valid, output angle_bits, input ready);
	modport sink (input valid, input angle_bits, output ready);
endinterface

interface fsc_sincos_if;
	logic        valid;
	logic        ready;
	logic [31:0] sine_bits;
	logic [31:0] cosine_bits;

	modport source (output valid, output sine_bits, output cosine_bits, input ready);
	modport sink (input valid, input sine_bits, input cosine_bits, output ready);
endinterface
`default_nettype wire

@@ src/fsc_delay.sv @@
// ----------------------------------------------------------------------------
// fsc_delay
// Enable-gated shift line keeping side data aligned with the float units.
// ----------------------------------------------------------------------------
`default_nettype none
module fsc_delay #(
	parameter int unsigned W = 32,
	parameter int unsigned D = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic [W-1:0]      q
);
	logic [W-1:0] taps_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			taps_q[0] <= d;
			for (int i = 1; i < int'(D); i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end
	end

	assign q = taps_q[D-1];
endmodule
`default_nettype wire

@@ src/fsc_fmul.sv @@
// ----------------------------------------------------------------------------
// fsc_fmul
// Three-stage float32 multiplier: multiply, normalise, round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none
module fsc_fmul (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic [31:0]      r
);
	import fsc_pkg::*;

	logic               spec_s1;
	logic [31:0]        spec_bits_s1;
	logic               sign_s1;
	logic signed [11:0] expo_s1;
	logic [47:0]        prod_s1;
	fsc_unr_t           unr_s2;
	logic [31:0]        res_s3;

	logic        a_inf, b_inf, a_zero, b_zero;
	logic [7:0]  ea, eb;
	logic [23:0] ma, mb;
	logic        spec_c;
	logic [31:0] spec_bits_c;

	always_comb begin
		a_inf = a[30:0] == PosInf[30:0];
		b_inf = b[30:0] == PosInf[30:0];
		a_zero = a[30:0] == 31'b0;
		b_zero = b[30:0] == 31'b0;
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		spec_c = 1'b1;
		spec_bits_c = DefaultNan;
		if (is_nan(a)) begin
			spec_bits_c = a;
		end else if (is_nan(b)) begin
			spec_bits_c = b;
		end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
			spec_bits_c = DefaultNan;
		end else if (a_inf || b_inf) begin
			spec_bits_c = {a[31] ^ b[31], PosInf[30:0]};
		end else begin
			spec_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1 <= spec_c;
			spec_bits_s1 <= spec_bits_c;
			sign_s1 <= a[31] ^ b[31];
			expo_s1 <= $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd126;
			prod_s1 <= ma * mb;
		end
	end

	logic [LzW-1:0] lz;
	logic [47:0]    pn;

	always_comb begin
		lz = lzc48(prod_s1);
		pn = prod_s1 << lz;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unr_s2.spec <= spec_s1;
			unr_s2.spec_bits <= spec_bits_s1;
			unr_s2.sign <= sign_s1;
			unr_s2.expo <= expo_s1 - $signed({6'b0, lz});
			unr_s2.mant <= {pn[47:23], |pn[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= unr_s2.spec ? unr_s2.spec_bits
				: round_pack(unr_s2.sign, unr_s2.expo, unr_s2.mant);
		end
	end

	assign r = res_s3;
endmodule
`default_nettype wire

@@ src/fsc_fadd.sv @@
// ----------------------------------------------------------------------------
// fsc_fadd
// Three-stage float32 adder/subtractor: align and add, normalise, round.
// ----------------------------------------------------------------------------
`default_nettype none
module fsc_fadd (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic        sub,
	output logic [31:0]      r
);
	import fsc_pkg::*;

	logic               spec_s1;
	logic [31:0]        spec_bits_s1;
	logic               sign_s1;
	logic               zsign_s1;
	logic signed [11:0] expo_s1;
	logic [27:0]        sum_s1;
	fsc_unr_t           unr_s2;
	logic [31:0]        res_s3;

	logic        sb;
	logic        a_inf, b_inf, swap;
	logic [31:0] hi, lo;
	logic        s_hi, s_lo;
	logic [7:0]  e_hi, e_lo, d;
	logic [4:0]  sh;
	logic [26:0] m_hi, m_lo, m_los;
	logic        lost;
	logic        spec_c;
	logic [31:0] spec_bits_c;
	logic [27:0] sum_c;

	always_comb begin
		sb = b[31] ^ sub;
		a_inf = a[30:0] == PosInf[30:0];
		b_inf = b[30:0] == PosInf[30:0];
		spec_c = 1'b1;
		spec_bits_c = DefaultNan;
		if (is_nan(a)) begin
			spec_bits_c = a;
		end else if (is_nan(b)) begin
			spec_bits_c = b;
		end else if (a_inf && b_inf && (a[31] != sb)) begin
			spec_bits_c = DefaultNan;
		end else if (a_inf) begin
			spec_bits_c = a;
		end else if (b_inf) begin
			spec_bits_c = {sb, PosInf[30:0]};
		end else begin
			spec_c = 1'b0;
		end
		swap = b[30:0] > a[30:0];
		hi = swap ? {sb, b[30:0]} : a;
		lo = swap ? a : {sb, b[30:0]};
		s_hi = hi[31];
		s_lo = lo[31];
		e_hi = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
		e_lo = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
		m_hi = {hi[30:23] != 8'd0, hi[22:0], 3'b0};
		m_lo = {lo[30:23] != 8'd0, lo[22:0], 3'b0};
		d = e_hi - e_lo;
		sh = (d > 8'd27) ? 5'd31 : d[4:0];
		lost = |(m_lo & ((27'd1 << sh) - 27'd1));
		m_los = m_lo >> sh;
		m_los[0] = m_los[0] | lost;
		if (s_hi != s_lo) begin
			sum_c = {1'b0, m_hi} - {1'b0, m_los};
		end else begin
			sum_c = {1'b0, m_hi} + {1'b0, m_los};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1 <= spec_c;
			spec_bits_s1 <= spec_bits_c;
			sign_s1 <= s_hi;
			zsign_s1 <= s_hi & s_lo;
			expo_s1 <= $signed({4'b0, e_hi}) + 12'sd1;
			sum_s1 <= sum_c;
		end
	end

	logic [LzW-1:0] lz;
	logic [27:0]    sn;

	always_comb begin
		lz = lzc48({sum_s1, 20'b0});
		sn = sum_s1 << lz;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unr_s2.spec <= spec_s1;
			unr_s2.spec_bits <= spec_bits_s1;
			unr_s2.sign <= (sum_s1 == '0) ? zsign_s1 : sign_s1;
			unr_s2.expo <= expo_s1 - $signed({6'b0, lz});
			unr_s2.mant <= {sn[27:3], |sn[2:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= unr_s2.spec ? unr_s2.spec_bits
				: round_pack(unr_s2.sign, unr_s2.expo, unr_s2.mant);
		end
	end

	assign r = res_s3;
endmodule
`default_nettype wire

@@ src/fsc_octant.sv @@
// ----------------------------------------------------------------------------
// fsc_octant
// Octant count: saturating truncation, round up to even, back to float32.
// ----------------------------------------------------------------------------
`default_nettype none
module fsc_octant (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] y,
	output logic [31:0]      jf,
	output logic [1:0]       oct
);
	import fsc_pkg::*;

	logic [31:0] j_s1;
	fsc_unr_t    unr_s2;
	logic [1:0]  oct_s2;
	logic [31:0] jf_s3;
	logic [1:0]  oct_s3;

	logic [31:0] jr, js;
	logic [4:0]  k;
	logic [54:0] t;

	always_comb begin
		k = y[27:23] - 5'd31;
		t = {31'b0, 1'b1, y[22:0]} << k;
		if (is_nan(y) || y[31] || (y[30:0] == 31'b0) || (y[30:23] < 8'd127)) begin
			jr = '0;
		end else if (y[30:23] >= 8'd159) begin
			jr = '1;
		end else begin
			jr = t[54:23];
		end
		js = jr + 32'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			j_s1 <= {js[31:1], 1'b0};
		end
	end

	logic [LzW-1:0] lz;
	logic [31:0]    jn;

	always_comb begin
		lz = lzc48({j_s1, 16'b0});
		jn = j_s1 << lz;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unr_s2.spec <= 1'b0;
			unr_s2.spec_bits <= '0;
			unr_s2.sign <= 1'b0;
			unr_s2.expo <= 12'sd158 - $signed({6'b0, lz});
			unr_s2.mant <= {jn[31:7], |jn[6:0]};
			oct_s2 <= j_s1[2:1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			jf_s3 <= round_pack(unr_s2.sign, unr_s2.expo, unr_s2.mant);
			oct_s3 <= oct_s2;
		end
	end

	assign jf = jf_s3;
	assign oct = oct_s3;
endmodule
`default_nettype wire

@@ src/float32_sincos_polynomial.sv @@
// ----------------------------------------------------------------------------
// float32_sincos_polynomial
// Float32 sine and cosine of one angle by octant reduction and polynomials.
// ----------------------------------------------------------------------------
// datapath: each item runs from accept to result valid through a chain of
//   three-stage float multiply and add units plus the output register
// throughput: one item per cycle; a stalled result freezes the whole pipeline
// reset: arst_n clears all valid bits; data registers are not reset
`default_nettype none
module float32_sincos_polynomial (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fsc_angle_if.sink    angle,
	fsc_sincos_if.source result
);
	import fsc_pkg::*;

	localparam int unsigned Lat = 46;

	logic [Lat-1:0] vld_q;
	logic           en;
	logic [31:0]    sine_q, cosine_q;

	assign en = ~vld_q[Lat-1] | result.ready;
	assign angle.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], angle.valid};
		end
	end

	logic [31:0] x0, y, jf, x_d9, ya, yb, yc, x1, x2, x3;
	logic [31:0] yb_d3, yc_d6;
	logic [1:0]  oct, oct_d;
	logic [31:0] z, z6, z12, z15, x3_18, x3_21;
	logic [31:0] p0, q0, h, h15, p1, q1, p2, q2, p3, q3, p4, q4, p5, q5;
	logic [31:0] p6, q6, p7, q7, q7d, ang_d;

	assign x0 = {1'b0, angle.angle_bits[30:0]};

	fsc_fmul u_mul_y (.clk, .en, .a(x0), .b(KFourOverPi), .r(y));
	fsc_octant u_oct (.clk, .en, .y, .jf, .oct);
	fsc_delay #(.W(32), .D(9)) u_dx (.clk, .en, .d(x0), .q(x_d9));

	fsc_fmul u_mul_a (.clk, .en, .a(jf), .b(KRedA), .r(ya));
	fsc_fmul u_mul_b (.clk, .en, .a(jf), .b(KRedB), .r(yb));
	fsc_fmul u_mul_c (.clk, .en, .a(jf), .b(KRedC), .r(yc));
	fsc_delay #(.W(32), .D(3)) u_dyb (.clk, .en, .d(yb), .q(yb_d3));
	fsc_delay #(.W(32), .D(6)) u_dyc (.clk, .en, .d(yc), .q(yc_d6));

	fsc_fadd u_add_1 (.clk, .en, .a(x_d9), .b(ya), .sub(1'b0), .r(x1));
	fsc_fadd u_add_2 (.clk, .en, .a(x1), .b(yb_d3), .sub(1'b0), .r(x2));
	fsc_fadd u_add_3 (.clk, .en, .a(x2), .b(yc_d6), .sub(1'b0), .r(x3));

	fsc_fmul u_mul_z (.clk, .en, .a(x3), .b(x3), .r(z));
	fsc_delay #(.W(32), .D(6)) u_dz6 (.clk, .en, .d(z), .q(z6));
	fsc_delay #(.W(32), .D(6)) u_dz12 (.clk, .en, .d(z6), .q(z12));
	fsc_delay #(.W(32), .D(3)) u_dz15 (.clk, .en, .d(z12), .q(z15));
	fsc_delay #(.W(32), .D(18)) u_dx18 (.clk, .en, .d(x3), .q(x3_18));
	fsc_delay #(.W(32), .D(3)) u_dx21 (.clk, .en, .d(x3_18), .q(x3_21));

	fsc_fmul u_mul_p0 (.clk, .en, .a(z), .b(KC0), .r(p0));
	fsc_fmul u_mul_q0 (.clk, .en, .a(z), .b(KS0), .r(q0));
	fsc_fmul u_mul_h (.clk, .en, .a(z), .b(KHalf), .r(h));
	fsc_delay #(.W(32), .D(15)) u_dh (.clk, .en, .d(h), .q(h15));

	fsc_fadd u_add_p1 (.clk, .en, .a(p0), .b(KC1), .sub(1'b0), .r(p1));
	fsc_fadd u_add_q1 (.clk, .en, .a(q0), .b(KS1), .sub(1'b0), .r(q1));
	fsc_fmul u_mul_p2 (.clk, .en, .a(p1), .b(z6), .r(p2));
	fsc_fmul u_mul_q2 (.clk, .en, .a(q1), .b(z6), .r(q2));
	fsc_fadd u_add_p3 (.clk, .en, .a(p2), .b(KC2), .sub(1'b0), .r(p3));
	fsc_fadd u_add_q3 (.clk, .en, .a(q2), .b(KS2), .sub(1'b0), .r(q3));
	fsc_fmul u_mul_p4 (.clk, .en, .a(p3), .b(z12), .r(p4));
	fsc_fmul u_mul_q4 (.clk, .en, .a(q3), .b(z12), .r(q4));
	fsc_fmul u_mul_p5 (.clk, .en, .a(p4), .b(z15), .r(p5));
	fsc_fmul u_mul_q5 (.clk, .en, .a(q4), .b(x3_18), .r(q5));
	fsc_fadd u_add_p6 (.clk, .en, .a(p5), .b(h15), .sub(1'b1), .r(p6));
	fsc_fadd u_add_q6 (.clk, .en, .a(q5), .b(x3_21), .sub(1'b0), .r(q6));
	fsc_fadd u_add_p7 (.clk, .en, .a(p6), .b(KOne), .sub(1'b0), .r(p7));
	assign q7 = q6;
	fsc_delay #(.W(32), .D(3)) u_dq (.clk, .en, .d(q7), .q(q7d));

	fsc_delay #(.W(2), .D(39)) u_doct (.clk, .en, .d(oct), .q(oct_d));
	fsc_delay #(.W(32), .D(45)) u_dang (.clk, .en, .d(angle.angle_bits), .q(ang_d));

	logic        nan_in, neg;
	logic [31:0] qn, ys, yc_sel, sb, cb;

	always_comb begin
		nan_in = ang_d[30:0] > PosInf[30:0];
		neg = ang_d[31] & (ang_d[30:0] != 31'b0);
		qn = {1'b0, ang_d[30:0]} | QuietBit;
		ys = oct_d[0] ? p7 : q7d;
		yc_sel = oct_d[0] ? q7d : p7;
		sb = {ys[31] ^ neg ^ oct_d[1], ys[30:0]};
		cb = {yc_sel[31] ^ (oct_d[1] ^ oct_d[0]), yc_sel[30:0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine_q <= nan_in ? qn : sb;
			cosine_q <= nan_in ? qn : cb;
		end
	end

	assign result.valid = vld_q[Lat-1];
	assign result.sine_bits = sine_q;
	assign result.cosine_bits = cosine_q;
endmodule
`default_nettype wire

@@ src/fsc_check.sv @@
// ----------------------------------------------------------------------------
// fsc_check
// Port-level checks on the sine/cosine pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module fsc_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] sine_bits,
	input wire logic [31:0] cosine_bits
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sine_bits) && $stable(cosine_bits))
		else $error("result item changed while stalled");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while result stalled");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline stalled with no result waiting");

	a_rst: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");
endmodule

bind float32_sincos_polynomial fsc_check u_fsc_check (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(angle.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.sine_bits(result.sine_bits),
	.cosine_bits(result.cosine_bits)
);
`default_nettype wire
